// File: design/tabular_q_learning_engine_defines.svh
// ============================================================================
// Assertion macros for the tabular Q-learning engine
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef TABULAR_Q_LEARNING_ENGINE_DEFINES_SVH
`define TABULAR_Q_LEARNING_ENGINE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TQLE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define TQLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tqle_pkg.sv
// ============================================================================
// Tabular Q-learning engine package
// Field widths, register codes, request codes and controller commands.
// ============================================================================
package tqle_pkg;

    localparam int TQLE_STATE_BINS   = 16;
    localparam int TQLE_ACTION_COUNT = 4;

    localparam int REQ_W      = 2;
    localparam int BIN_W      = 4;
    localparam int ACT_W      = 2;
    localparam int Q_W        = 16;
    localparam int PERMILLE_W = 10;
    localparam int RATE_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Update arithmetic widths
    localparam int P1_W   = RATE_W + 1 + Q_W;   // gamma * max
    localparam int TGT_W  = P1_W - 8 + 1;       // reward + scaled max
    localparam int DIFF_W = TGT_W + 1;          // target - cur
    localparam int P2_W   = RATE_W + 1 + DIFF_W; // alpha * diff
    localparam int SUM_W  = P2_W - 8 + 1;       // cur + delta

    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd2;

    localparam logic [PERMILLE_W-1:0] EXPLORE_RESET  = 10'd100;
    localparam logic [RATE_W-1:0]     LEARN_RESET    = 9'd26;
    localparam logic [RATE_W-1:0]     DISCOUNT_RESET = 9'd230;

    typedef enum logic [REQ_W-1:0] {
        REQ_SELECT = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_SEL,
        RES_UPD,
        RES_RD
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     clr_wr;
        logic     row_rd;
        logic     row_next;
        logic     ent_rd;
        logic     mul1;
        logic     mul2;
        logic     wb;
        logic     res_load;
        res_sel_t res_sel;
    } tqle_cmd_t;

    function automatic logic [31:0] tqle_clamp(input logic [31:0] v, input logic [31:0] hi);
        return (v > hi) ? hi : v;
    endfunction

endpackage

// File: design/tqle_ctrl.sv
// ============================================================================
// Tabular Q-learning engine controller
// Sequences the table clearing pass and each request through the datapath.
// ============================================================================
module tqle_ctrl
    import tqle_pkg::*;
#(
    parameter int STATE_BINS   = TQLE_STATE_BINS,
    parameter int ACTION_COUNT = TQLE_ACTION_COUNT,
    parameter int MAW          = $clog2(STATE_BINS * STATE_BINS * ACTION_COUNT)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REQ_W-1:0] req_type,
    output logic             busy,
    output tqle_cmd_t        cmd,
    output logic [MAW-1:0]   cnt
);

    localparam int DEPTH = STATE_BINS * STATE_BINS * ACTION_COUNT;
    localparam logic [MAW-1:0] CNT_CLR_LAST = MAW'(DEPTH - 1);
    localparam logic [MAW-1:0] CNT_ROW_LAST = MAW'(ACTION_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_ROWW,
        S_ENT,
        S_ENTW,
        S_MUL1,
        S_MUL2,
        S_WB,
        S_FIN
    } state_t;

    state_t         state_reg, state_next;
    logic [MAW-1:0] cnt_reg, cnt_next;
    req_t           req_reg, req_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (cnt_reg == CNT_CLR_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    req_next    = req_t'(req_type);
                    cnt_next    = '0;
                    case (req_t'(req_type))
                        REQ_SELECT: state_next = S_ROW;
                        REQ_UPDATE: state_next = S_ROW;
                        REQ_READ:   state_next = S_ENT;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_ROW:
            begin
                cmd.row_rd   = 1'b1;
                cmd.row_next = (req_reg == REQ_UPDATE);
                if (cnt_reg == CNT_ROW_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_ROWW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROWW:
            begin
                if (req_reg == REQ_UPDATE)
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_MUL1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ENT:
            begin
                cmd.ent_rd = 1'b1;
                state_next = S_ENTW;
            end
            S_ENTW:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_RD;
                state_next   = S_IDLE;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb       = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_UPD;
                state_next   = S_IDLE;
            end
            S_FIN:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = (req_reg == REQ_SELECT) ? RES_SEL : RES_NONE;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            req_reg   <= REQ_NONE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            req_reg   <= req_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cnt  = cnt_reg;

endmodule

// File: design/tqle_datapath.sv
// ============================================================================
// Tabular Q-learning engine datapath
// Q table memory, configuration registers, row maximum search, update
// arithmetic and result registers.
// ============================================================================
module tqle_datapath
    import tqle_pkg::*;
#(
    parameter int STATE_BINS   = TQLE_STATE_BINS,
    parameter int ACTION_COUNT = TQLE_ACTION_COUNT,
    parameter int MAW          = $clog2(STATE_BINS * STATE_BINS * ACTION_COUNT)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tqle_cmd_t              cmd,
    input  logic [MAW-1:0]         cnt,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [BIN_W-1:0]       state_x,
    input  logic [BIN_W-1:0]       state_y,
    input  logic [ACT_W-1:0]       action_index,
    input  logic [BIN_W-1:0]       next_x,
    input  logic [BIN_W-1:0]       next_y,
    input  logic signed [Q_W-1:0]  reward,
    input  logic [PERMILLE_W-1:0]  explore_draw,
    input  logic [ACT_W-1:0]       random_action,
    output logic                   done,
    output logic [ACT_W-1:0]       chosen_action,
    output logic                   explored,
    output logic signed [Q_W-1:0]  q_value
);

    localparam int DEPTH = STATE_BINS * STATE_BINS * ACTION_COUNT;
    localparam int XW    = $clog2(STATE_BINS);
    localparam int AW    = $clog2(ACTION_COUNT);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    logic [PERMILLE_W-1:0] explore_permille_reg;
    logic [RATE_W-1:0]     learn_rate_reg;
    logic [RATE_W-1:0]     discount_reg;

    logic [XW-1:0]          sx_reg, sy_reg, nx_reg, ny_reg;
    logic [AW-1:0]          act_reg, ract_reg;
    logic signed [Q_W-1:0]  reward_reg;
    logic                   explore_reg;

    logic signed [Q_W-1:0]  q_mem [DEPTH];
    logic signed [Q_W-1:0]  rd_data_reg;
    logic                   rd_pend_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic signed [Q_W-1:0]  max_reg;
    logic [AW-1:0]          best_reg;

    logic signed [Q_W-1:0]  cur_reg;
    logic signed [P1_W-1:0] p1_reg;
    logic signed [P2_W-1:0] p2_reg;

    logic                   done_reg;
    logic [ACT_W-1:0]       chosen_reg;
    logic                   explored_reg;
    logic signed [Q_W-1:0]  q_reg;

    logic [31:0]            cur_base, nxt_base;
    logic [MAW-1:0]         ent_addr, row_addr, rd_addr, wr_addr;
    logic                   mem_rd, mem_we;
    logic signed [Q_W-1:0]  wr_data;
    logic signed [TGT_W-1:0]  target;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
    logic signed [Q_W-1:0]  new_val;

    always_comb
    begin
        cur_base = 32'((32'(sx_reg) * 32'(STATE_BINS) + 32'(sy_reg)) * 32'(ACTION_COUNT));
        nxt_base = 32'((32'(nx_reg) * 32'(STATE_BINS) + 32'(ny_reg)) * 32'(ACTION_COUNT));
        ent_addr = MAW'(cur_base + 32'(act_reg));
        row_addr = MAW'((cmd.row_next ? nxt_base : cur_base) + 32'(cnt[AW-1:0]));
        mem_rd   = cmd.row_rd | cmd.ent_rd;
        rd_addr  = cmd.row_rd ? row_addr : ent_addr;
        mem_we   = cmd.clr_wr | cmd.wb;
        wr_addr  = cmd.clr_wr ? cnt : ent_addr;
    end

    always_comb
    begin
        target = TGT_W'(reward_reg) + TGT_W'(p1_reg >>> 8);
        diff   = DIFF_W'(target) - DIFF_W'(cur_reg);
        sum    = SUM_W'(cur_reg) + SUM_W'(p2_reg >>> 8);
        if (sum > SAT_MAX)
        begin
            new_val = Q_W'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            new_val = Q_W'(SAT_MIN);
        end
        else
        begin
            new_val = Q_W'(sum);
        end
        wr_data = cmd.clr_wr ? '0 : new_val;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            q_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_data_reg <= q_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            explore_permille_reg <= EXPLORE_RESET;
            learn_rate_reg       <= LEARN_RESET;
            discount_reg         <= DISCOUNT_RESET;
            rd_pend_reg          <= 1'b0;
            done_reg             <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_EXPLORE:  explore_permille_reg <= cfg_data;
                    CFG_LEARN:    learn_rate_reg       <= cfg_data[RATE_W-1:0];
                    CFG_DISCOUNT: discount_reg         <= cfg_data[RATE_W-1:0];
                    default:      ;
                endcase
            end
            rd_pend_reg <= cmd.row_rd;
            done_reg    <= cmd.res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg      <= XW'(tqle_clamp(32'(state_x), 32'(STATE_BINS - 1)));
            sy_reg      <= XW'(tqle_clamp(32'(state_y), 32'(STATE_BINS - 1)));
            nx_reg      <= XW'(tqle_clamp(32'(next_x), 32'(STATE_BINS - 1)));
            ny_reg      <= XW'(tqle_clamp(32'(next_y), 32'(STATE_BINS - 1)));
            act_reg     <= AW'(tqle_clamp(32'(action_index), 32'(ACTION_COUNT - 1)));
            ract_reg    <= AW'(tqle_clamp(32'(random_action), 32'(ACTION_COUNT - 1)));
            reward_reg  <= reward;
            explore_reg <= (explore_draw < explore_permille_reg);
        end
        rd_idx_reg <= cnt[AW-1:0];
        if (rd_pend_reg)
        begin
            if ((rd_idx_reg == '0) || (rd_data_reg > max_reg))
            begin
                max_reg  <= rd_data_reg;
                best_reg <= rd_idx_reg;
            end
        end
        if (cmd.mul1)
        begin
            cur_reg <= rd_data_reg;
            p1_reg  <= P1_W'($signed({1'b0, discount_reg})) * P1_W'(max_reg);
        end
        if (cmd.mul2)
        begin
            p2_reg <= P2_W'($signed({1'b0, learn_rate_reg})) * P2_W'(diff);
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_SEL:
                begin
                    chosen_reg   <= explore_reg ? ACT_W'(ract_reg) : ACT_W'(best_reg);
                    explored_reg <= explore_reg;
                    q_reg        <= max_reg;
                end
                RES_UPD:
                begin
                    chosen_reg   <= ACT_W'(act_reg);
                    explored_reg <= 1'b0;
                    q_reg        <= new_val;
                end
                RES_RD:
                begin
                    chosen_reg   <= ACT_W'(act_reg);
                    explored_reg <= 1'b0;
                    q_reg        <= rd_data_reg;
                end
                default:
                begin
                    chosen_reg   <= '0;
                    explored_reg <= 1'b0;
                    q_reg        <= '0;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign chosen_action = chosen_reg;
    assign explored      = explored_reg;
    assign q_value       = q_reg;

endmodule

// File: design/tabular_q_learning_engine.sv
// ============================================================================
// Tabular Q-learning engine
// Epsilon-greedy action selection, Q-value update and entry read on a Q8.8
// table indexed by two state bins and an action.
// ============================================================================
// A request is taken when start is high and busy is low; its single result is
// shown for one cycle with done high and must be captured then, since there
// is no way to hold it off. A new request may be given in the done cycle.
// The table has a single read port: one entry per cycle is read while
// scanning a row. After reset busy stays high while the table is cleared;
// configuration writes are taken at any time.
`include "tabular_q_learning_engine_defines.svh"

module tabular_q_learning_engine
    import tqle_pkg::*;
#(
    parameter int STATE_BINS   = TQLE_STATE_BINS,
    parameter int ACTION_COUNT = TQLE_ACTION_COUNT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [BIN_W-1:0]       state_x,
    input  logic [BIN_W-1:0]       state_y,
    input  logic [ACT_W-1:0]       action_index,
    input  logic [BIN_W-1:0]       next_x,
    input  logic [BIN_W-1:0]       next_y,
    input  logic signed [Q_W-1:0]  reward,
    input  logic [PERMILLE_W-1:0]  explore_draw,
    input  logic [ACT_W-1:0]       random_action,
    output logic                   done,
    output logic [ACT_W-1:0]       chosen_action,
    output logic                   explored,
    output logic signed [Q_W-1:0]  q_value
);

    localparam int MAW = $clog2(STATE_BINS * STATE_BINS * ACTION_COUNT);

    tqle_cmd_t      cmd;
    logic [MAW-1:0] cnt;

    tqle_ctrl #(
        .STATE_BINS   (STATE_BINS),
        .ACTION_COUNT (ACTION_COUNT),
        .MAW          (MAW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .cmd      (cmd),
        .cnt      (cnt)
    );

    tqle_datapath #(
        .STATE_BINS   (STATE_BINS),
        .ACTION_COUNT (ACTION_COUNT),
        .MAW          (MAW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cnt           (cnt),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .state_x       (state_x),
        .state_y       (state_y),
        .action_index  (action_index),
        .next_x        (next_x),
        .next_y        (next_y),
        .reward        (reward),
        .explore_draw  (explore_draw),
        .random_action (random_action),
        .done          (done),
        .chosen_action (chosen_action),
        .explored      (explored),
        .q_value       (q_value)
    );

    `TQLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but busy not raised")
    `TQLE_ASSERT_IMPLY(a_done_idle, done, !busy, "result strobe while a request is in progress")
    `TQLE_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")

endmodule

// File: tb/tb.sv
// ============================================================================
// Tabular Q-learning engine testbench
// Sends select, update, read and unused-code requests through the start/busy
// handshake and checks every result against an in-bench model of the Q table,
// across several settings of epsilon, alpha and gamma.
// ============================================================================
module tb
    import tqle_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4096;
    localparam int SETTLE_CYCLES  = 24;

    typedef struct packed {
        req_t                  kind;
        logic [BIN_W-1:0]      sx;
        logic [BIN_W-1:0]      sy;
        logic [ACT_W-1:0]      act;
        logic [BIN_W-1:0]      nx;
        logic [BIN_W-1:0]      ny;
        logic signed [Q_W-1:0] reward;
        logic [PERMILLE_W-1:0] draw;
        logic [ACT_W-1:0]      ract;
    } q_request_t;

    typedef struct packed {
        logic [ACT_W-1:0]      act;
        logic                  expl;
        logic signed [Q_W-1:0] q;
    } q_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    req_t                  req_type = REQ_SELECT;
    logic [BIN_W-1:0]      state_x = '0;
    logic [BIN_W-1:0]      state_y = '0;
    logic [ACT_W-1:0]      action_index = '0;
    logic [BIN_W-1:0]      next_x = '0;
    logic [BIN_W-1:0]      next_y = '0;
    logic signed [Q_W-1:0] reward = '0;
    logic [PERMILLE_W-1:0] explore_draw = '0;
    logic [ACT_W-1:0]      random_action = '0;
    logic                  done;
    logic [ACT_W-1:0]      chosen_action;
    logic                  explored;
    logic signed [Q_W-1:0] q_value;

    logic signed [Q_W-1:0] q_tbl [0:1023];
    logic [PERMILLE_W-1:0] explore_pm;
    logic [RATE_W-1:0]     learn_rt;
    logic [RATE_W-1:0]     discount_rt;

    q_result_t expected_results[$];
    int        mismatch_count = 0;
    int        idle_count = 0;

    tabular_q_learning_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .state_x       (state_x),
        .state_y       (state_y),
        .action_index  (action_index),
        .next_x        (next_x),
        .next_y        (next_y),
        .reward        (reward),
        .explore_draw  (explore_draw),
        .random_action (random_action),
        .done          (done),
        .chosen_action (chosen_action),
        .explored      (explored),
        .q_value       (q_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [Q_W-1:0] row_peak(input logic [BIN_W-1:0] x,
                                                       input logic [BIN_W-1:0] y,
                                                       output logic [ACT_W-1:0] first);
        logic signed [Q_W-1:0] peak;
        peak  = q_tbl[{x, y, 2'd0}];
        first = '0;
        for (int a = 1; a < TQLE_ACTION_COUNT; a++)
        begin
            if (q_tbl[{x, y, ACT_W'(a)}] > peak)
            begin
                peak  = q_tbl[{x, y, ACT_W'(a)}];
                first = ACT_W'(a);
            end
        end
        return peak;
    endfunction

    function automatic q_result_t predict_result(input q_request_t r);
        q_result_t             res;
        logic [ACT_W-1:0]      greedy;
        logic signed [Q_W-1:0] peak;
        logic [9:0]            idx;
        longint                cur;
        longint                target;
        longint                sum;
        res = '0;
        idx = {r.sx, r.sy, r.act};
        case (r.kind)
            REQ_SELECT:
            begin
                peak  = row_peak(r.sx, r.sy, greedy);
                res.q = peak;
                if (r.draw < explore_pm)
                begin
                    res.act  = r.ract;
                    res.expl = 1'b1;
                end
                else
                begin
                    res.act = greedy;
                end
            end
            REQ_UPDATE:
            begin
                cur    = q_tbl[idx];
                peak   = row_peak(r.nx, r.ny, greedy);
                target = longint'(r.reward) + ((longint'(discount_rt) * longint'(peak)) >>> 8);
                sum    = cur + ((longint'(learn_rt) * (target - cur)) >>> 8);
                if (sum > 32767)
                    sum = 32767;
                else if (sum < -32768)
                    sum = -32768;
                res.q      = Q_W'(sum);
                res.act    = r.act;
                q_tbl[idx] = res.q;
            end
            REQ_READ:
            begin
                res.q   = q_tbl[idx];
                res.act = r.act;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic q_request_t make_request(input req_t kind,
                                                input logic [BIN_W-1:0] sx, sy,
                                                input logic [ACT_W-1:0] act,
                                                input logic [BIN_W-1:0] nx, ny,
                                                input logic signed [Q_W-1:0] rw,
                                                input logic [PERMILLE_W-1:0] draw,
                                                input logic [ACT_W-1:0] ract);
        q_request_t r;
        r.kind   = kind;
        r.sx     = sx;
        r.sy     = sy;
        r.act    = act;
        r.nx     = nx;
        r.ny     = ny;
        r.reward = rw;
        r.draw   = draw;
        r.ract   = ract;
        return r;
    endfunction

    // Keep most traffic on a few bins so entries get revisited.
    function automatic logic [BIN_W-1:0] pick_bin();
        if ($urandom_range(0, 3) == 0)
            return BIN_W'($urandom_range(0, 15));
        return BIN_W'($urandom_range(0, 2));
    endfunction

    function automatic q_request_t random_request();
        q_request_t r;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.kind = REQ_SELECT;
        else if (pick < 75)
            r.kind = REQ_UPDATE;
        else if (pick < 95)
            r.kind = REQ_READ;
        else
            r.kind = REQ_NONE;
        r.sx   = pick_bin();
        r.sy   = pick_bin();
        r.nx   = pick_bin();
        r.ny   = pick_bin();
        r.act  = ACT_W'($urandom_range(0, 3));
        r.ract = ACT_W'($urandom_range(0, 3));
        r.draw = PERMILLE_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 4))
            0: r.reward = Q_W'($urandom_range(0, 2047)) - 16'sd1024;
            1: r.reward = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
            2: r.reward = Q_W'($urandom_range(0, 16383)) - 16'sd8192;
            default: r.reward = Q_W'($urandom);
        endcase
        return r;
    endfunction

    task automatic send_request(input q_request_t r);
        start         <= 1'b1;
        req_type      <= r.kind;
        state_x       <= r.sx;
        state_y       <= r.sy;
        action_index  <= r.act;
        next_x        <= r.nx;
        next_y        <= r.ny;
        reward        <= r.reward;
        explore_draw  <= r.draw;
        random_action <= r.ract;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_result(r));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] e, l, d);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_EXPLORE;
        cfg_data  <= e;
        @(posedge clk);
        explore_pm = e;
        // drop: a write to an index past the list changes nothing
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_index <= CFG_LEARN;
        cfg_data  <= l;
        @(posedge clk);
        learn_rt = l[RATE_W-1:0];
        cfg_index <= CFG_DISCOUNT;
        cfg_data  <= d;
        @(posedge clk);
        discount_rt = d[RATE_W-1:0];
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_request(make_request(REQ_READ, 4'd0, 4'd0, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd0, 2'd0));
        send_request(make_request(REQ_READ, 4'd15, 4'd15, 2'd3, 4'd15, 4'd15, 16'sh7FFF,
                                  10'd1023, 2'd3));
        send_request(make_request(REQ_SELECT, 4'd5, 4'd9, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd99, 2'd2));
        send_request(make_request(REQ_SELECT, 4'd5, 4'd9, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd100, 2'd3));
    endtask

    task automatic test_update_arithmetic();
        send_request(make_request(REQ_UPDATE, 4'd1, 4'd1, 2'd1, 4'd1, 4'd1, 16'sh7FFF, 10'd0, 2'd0));
        send_request(make_request(REQ_UPDATE, 4'd1, 4'd1, 2'd2, 4'd15, 4'd15, 16'sh8000,
                                  10'd0, 2'd0));
        send_request(make_request(REQ_UPDATE, 4'd1, 4'd1, 2'd3, 4'd1, 4'd1, 16'sh7FFF, 10'd0, 2'd0));
        send_request(make_request(REQ_SELECT, 4'd1, 4'd1, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd999, 2'd0));
        send_request(make_request(REQ_SELECT, 4'd1, 4'd1, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd0, 2'd2));
        send_request(make_request(REQ_READ, 4'd1, 4'd1, 2'd1, 4'd0, 4'd0, 16'sd0, 10'd0, 2'd0));
        // equal values in actions 1 and 3: greedy takes the lower one
        send_request(make_request(REQ_UPDATE, 4'd2, 4'd2, 2'd1, 4'd0, 4'd0, 16'sd5000, 10'd0, 2'd0));
        send_request(make_request(REQ_UPDATE, 4'd2, 4'd2, 2'd3, 4'd0, 4'd0, 16'sd5000, 10'd0, 2'd0));
        send_request(make_request(REQ_SELECT, 4'd2, 4'd2, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd1023, 2'd0));
        send_request(make_request(REQ_NONE, 4'd15, 4'd15, 2'd3, 4'd15, 4'd15, 16'shFFFF,
                                  10'd1023, 2'd3));
    endtask

    task automatic test_rate_limits();
        drain();
        configure(10'd0, 10'd256, 10'd256);
        send_request(make_request(REQ_UPDATE, 4'd3, 4'd3, 2'd0, 4'd1, 4'd1, 16'sh7FFF, 10'd0, 2'd0));
        send_request(make_request(REQ_SELECT, 4'd3, 4'd3, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd0, 2'd1));
        drain();
        configure(10'd1023, 10'd1023, 10'd511);
        send_request(make_request(REQ_UPDATE, 4'd3, 4'd3, 2'd1, 4'd1, 4'd1, 16'sh8000, 10'd0, 2'd0));
        send_request(make_request(REQ_UPDATE, 4'd3, 4'd3, 2'd2, 4'd1, 4'd1, 16'sh7FFF, 10'd0, 2'd0));
        send_request(make_request(REQ_SELECT, 4'd3, 4'd3, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd1023, 2'd1));
        send_request(make_request(REQ_SELECT, 4'd3, 4'd3, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd1000, 2'd1));
        drain();
        configure(10'd1000, 10'd0, 10'd0);
        send_request(make_request(REQ_UPDATE, 4'd3, 4'd3, 2'd0, 4'd1, 4'd1, 16'sh8000, 10'd0, 2'd0));
        send_request(make_request(REQ_SELECT, 4'd3, 4'd3, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd999, 2'd3));
        send_request(make_request(REQ_SELECT, 4'd3, 4'd3, 2'd0, 4'd0, 4'd0, 16'sd0, 10'd1000, 2'd3));
    endtask

    task automatic test_random_traffic(input int count, input logic [CFG_DATA_W-1:0] e, l, d,
                                       input int idle_pct);
        int quiet_left;
        quiet_left = 0;
        drain();
        configure(e, l, d);
        for (int i = 0; i < count; i++)
        begin
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 9) == 0)
                quiet_left = $urandom_range(10, 40);
            else if ($urandom_range(0, 99) < idle_pct)
                idle_cycles($urandom_range(1, 13));
            send_request(random_request());
        end
    endtask

    always @(posedge clk)
    begin
        q_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual act=%0d expl=%0d q=%0d",
                         $time, chosen_action, explored, q_value);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (chosen_action !== want.act)
                begin
                    $display("%0t chosen_action: expected %0d actual %0d",
                             $time, want.act, chosen_action);
                    mismatch_count++;
                end
                if (explored !== want.expl)
                begin
                    $display("%0t explored: expected %0d actual %0d", $time, want.expl, explored);
                    mismatch_count++;
                end
                if (q_value !== want.q)
                begin
                    $display("%0t q_value: expected %0d actual %0d", $time, want.q, q_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        foreach (q_tbl[i])
            q_tbl[i] = '0;
        explore_pm  = EXPLORE_RESET;
        learn_rt    = LEARN_RESET;
        discount_rt = DISCOUNT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_update_arithmetic();
        test_rate_limits();
        test_random_traffic(150, 10'd100, 10'd26, 10'd230, 30);
        test_random_traffic(150, 10'd1000, 10'd256, 10'd256, 30);
        test_random_traffic(150, 10'd0, 10'd1, 10'd1, 20);
        test_random_traffic(150, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom), 30);
        // hold start high through the last stretch
        test_random_traffic(200, CFG_DATA_W'($urandom_range(0, 1000)),
                            CFG_DATA_W'($urandom_range(0, 256)),
                            CFG_DATA_W'($urandom_range(0, 256)), 0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t missing results: expected %0d more actual 0",
                     $time, expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: tabular_q_learning_engine.f
+incdir+design
design/tqle_pkg.sv
design/tqle_ctrl.sv
design/tqle_datapath.sv
design/tabular_q_learning_engine.sv
tb/tb.sv
